// ===== design/lobm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limit order book package
// Shared types and codes for the order book matcher: slot entry layout,
// scan result flags, request modes, result status codes and sides.
// ----------------------------------------------------------------------------
package lobm_pkg;

   // Request modes.
   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_CANCEL = 2'd1;
   localparam logic [1:0] MODE_MODIFY = 2'd2;

   // Result status codes.
   localparam logic [2:0] ST_TRADE     = 3'd0;
   localparam logic [2:0] ST_ACCEPTED  = 3'd1;
   localparam logic [2:0] ST_DUPLICATE = 3'd2;
   localparam logic [2:0] ST_FAK_MISS  = 3'd3;
   localparam logic [2:0] ST_UNKNOWN   = 3'd4;
   localparam logic [2:0] ST_CANCELLED = 3'd5;
   localparam logic [2:0] ST_FULL      = 3'd6;

   // Sides and kinds.
   localparam logic SIDE_BUY  = 1'b0;
   localparam logic SIDE_SELL = 1'b1;
   localparam logic KIND_FAK  = 1'b1;

   // Trades made for one request at most, and the width of that count.
   localparam int TRADE_CNT_W = 7;
   localparam logic [TRADE_CNT_W-1:0] MAX_TRADES = 7'd64;

   // One resting order as held in the slot memory.
   typedef struct packed {
      logic [31:0]        order_id;
      logic               side;
      logic               kind;
      logic signed [31:0] price;
      logic [31:0]        remaining;
      logic [31:0]        arrival;
   } entry_type;

   // Outcome of one pass over the slot table.
   typedef struct packed {
      logic found;
      logic found_kind;
      logic free_found;
      logic bid_found;
      logic ask_found;
   } scan_flags_type;

endpackage

// ===== design/lobm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order book channel interfaces
// Valid/ready channels for requests into the book and results out of it.
// ----------------------------------------------------------------------------
interface lobm_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [31:0]        order_id;
   logic               side;
   logic               kind;
   logic signed [31:0] price;
   logic [31:0]        quantity;

   modport source (output valid, mode, order_id, side, kind, price, quantity,
                   input ready);
   modport sink (input valid, mode, order_id, side, kind, price, quantity,
                 output ready);
endinterface

interface lobm_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [31:0]        bid_id;
   logic signed [31:0] bid_price;
   logic [31:0]        ask_id;
   logic signed [31:0] ask_price;
   logic [31:0]        fill_quantity;
   logic               last;

   modport source (output valid, status, bid_id, bid_price, ask_id, ask_price,
                   fill_quantity, last, input ready);
   modport sink (input valid, status, bid_id, bid_price, ask_id, ask_price,
                 fill_quantity, last, output ready);
endinterface

// ===== design/lobm_slot_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order book slot memory
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module lobm_slot_mem #(
   parameter int SLOTS = 64
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(SLOTS)-1:0]   wr_addr,
   input  lobm_pkg::entry_type        wr_data,
   input  logic [$clog2(SLOTS)-1:0]   rd_addr,
   output lobm_pkg::entry_type        rd_data
);
   import lobm_pkg::*;

   entry_type mem [SLOTS];
   entry_type rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/lobm_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order book scan unit
// Looks at one slot a cycle and keeps the id match, the first free slot
// and the best bid and ask in price then arrival order.
// ----------------------------------------------------------------------------
module lobm_scan #(
   parameter int SLOTS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clr,
   input  logic                       eval,
   input  lobm_pkg::entry_type        ent,
   input  logic                       ent_live,
   input  logic [$clog2(SLOTS)-1:0]   ent_idx,
   input  logic [31:0]                key_id,
   output lobm_pkg::scan_flags_type   flags,
   output logic [$clog2(SLOTS)-1:0]   found_idx,
   output logic [$clog2(SLOTS)-1:0]   free_idx,
   output logic [$clog2(SLOTS)-1:0]   bid_idx,
   output logic [$clog2(SLOTS)-1:0]   ask_idx,
   output lobm_pkg::entry_type        bid_ent,
   output lobm_pkg::entry_type        ask_ent
);
   import lobm_pkg::*;

   localparam int SLOT_W = $clog2(SLOTS);

   scan_flags_type    flags_ff;
   logic [SLOT_W-1:0] found_idx_ff;
   logic [SLOT_W-1:0] free_idx_ff;
   logic [SLOT_W-1:0] bid_idx_ff;
   logic [SLOT_W-1:0] ask_idx_ff;
   entry_type         bid_ent_ff;
   entry_type         ask_ent_ff;

   logic hit_id;
   logic hit_free;
   logic hit_bid;
   logic hit_ask;

   // Priority compare: better price wins, at equal price the earlier stamp.
   always_comb begin
      hit_id   = ent_live && (ent.order_id == key_id) && !flags_ff.found;
      hit_free = !ent_live && !flags_ff.free_found;
      hit_bid  = ent_live && (ent.side == SIDE_BUY) &&
                 (!flags_ff.bid_found ||
                  ((ent.price != bid_ent_ff.price) ? (ent.price > bid_ent_ff.price)
                                                    : (ent.arrival < bid_ent_ff.arrival)));
      hit_ask  = ent_live && (ent.side == SIDE_SELL) &&
                 (!flags_ff.ask_found ||
                  ((ent.price != ask_ent_ff.price) ? (ent.price < ask_ent_ff.price)
                                                    : (ent.arrival < ask_ent_ff.arrival)));
   end

   // Flags, cleared at the start of each pass.
   always_ff @(posedge clock) begin
      if (reset || clr) begin
         flags_ff <= '0;
      end else if (eval) begin
         if (hit_id) begin
            flags_ff.found      <= 1'b1;
            flags_ff.found_kind <= ent.kind;
         end
         if (hit_free) begin
            flags_ff.free_found <= 1'b1;
         end
         if (hit_bid) begin
            flags_ff.bid_found <= 1'b1;
         end
         if (hit_ask) begin
            flags_ff.ask_found <= 1'b1;
         end
      end
   end

   // Captured slot numbers and best entries.
   always_ff @(posedge clock) begin
      if (eval) begin
         if (hit_id) begin
            found_idx_ff <= ent_idx;
         end
         if (hit_free) begin
            free_idx_ff <= ent_idx;
         end
         if (hit_bid) begin
            bid_idx_ff <= ent_idx;
            bid_ent_ff <= ent;
         end
         if (hit_ask) begin
            ask_idx_ff <= ent_idx;
            ask_ent_ff <= ent;
         end
      end
   end

   assign flags     = flags_ff;
   assign found_idx = found_idx_ff;
   assign free_idx  = free_idx_ff;
   assign bid_idx   = bid_idx_ff;
   assign ask_idx   = ask_idx_ff;
   assign bid_ent   = bid_ent_ff;
   assign ask_ent   = ask_ent_ff;

endmodule

// ===== design/limit_order_book_matcher_top.sv =====
`timescale 1ns / 1ps
// A cancel takes one pass over the slot table, an add one pass plus one pass
// per trade and one more. Throughput: one request at a time; the next is taken
// once the last result is in the output register. Reset clears the slot valid
// bits, the arrival counter and the output register; the slot memory needs no
// clearing pass.
// ----------------------------------------------------------------------------
// Limit order book matcher
// Price-time priority book over a slot memory, with one scan unit reused
// under a sequencer for id lookup, free slot search and best price search.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_top #(
   parameter int ORDER_SLOTS = 64
) (
   input  logic       clock,
   input  logic       reset,
   lobm_req_if.sink   req_chan,
   lobm_rsp_if.source rsp_chan
);
   import lobm_pkg::*;

   localparam int SLOT_W = $clog2(ORDER_SLOTS);
   localparam int CNT_W  = $clog2(ORDER_SLOTS + 1);

   // Sequencer states.
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_LOOKUP = 3'd2;
   localparam logic [2:0] S_MATCH  = 3'd3;
   localparam logic [2:0] S_WR_BID = 3'd4;
   localparam logic [2:0] S_WR_ASK = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;
   localparam logic [2:0] S_REPLY  = 3'd7;

   logic [2:0]             state_ff, state_in;
   logic [1:0]             mode_ff, mode_in;
   logic [31:0]            id_ff, id_in;
   logic                   side_ff, side_in;
   logic                   kind_ff, kind_in;
   logic signed [31:0]     price_ff, price_in;
   logic [31:0]            qty_ff, qty_in;
   logic                   scan_match_ff, scan_match_in;
   logic [CNT_W-1:0]       scan_cnt_ff, scan_cnt_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic [SLOT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [ORDER_SLOTS-1:0] valid_ff, valid_in;
   logic [SLOT_W-1:0]      new_slot_ff, new_slot_in;
   logic [31:0]            arrival_ff, arrival_in;
   logic [TRADE_CNT_W-1:0] ntr_ff, ntr_in;
   logic                   pend_vld_ff, pend_vld_in;
   logic [31:0]            pend_bid_id_ff, pend_bid_id_in;
   logic signed [31:0]     pend_bid_pr_ff, pend_bid_pr_in;
   logic [31:0]            pend_ask_id_ff, pend_ask_id_in;
   logic signed [31:0]     pend_ask_pr_ff, pend_ask_pr_in;
   logic [31:0]            pend_fq_ff, pend_fq_in;
   logic [2:0]             reply_ff, reply_in;

   logic                   out_vld_ff, out_vld_in;
   logic [2:0]             out_status_ff, out_status_in;
   logic [31:0]            out_bid_id_ff, out_bid_id_in;
   logic signed [31:0]     out_bid_pr_ff, out_bid_pr_in;
   logic [31:0]            out_ask_id_ff, out_ask_id_in;
   logic signed [31:0]     out_ask_pr_ff, out_ask_pr_in;
   logic [31:0]            out_fq_ff, out_fq_in;
   logic                   out_last_ff, out_last_in;

   logic                   out_free;
   logic                   out_load;
   logic                   issue;
   logic                   scan_clr;
   logic                   mem_we;
   logic [SLOT_W-1:0]      mem_wa;
   entry_type              mem_wd;
   entry_type              rd_ent;
   scan_flags_type         flags;
   logic [SLOT_W-1:0]      found_idx;
   logic [SLOT_W-1:0]      free_idx;
   logic [SLOT_W-1:0]      bid_idx;
   logic [SLOT_W-1:0]      ask_idx;
   entry_type              bid_ent;
   entry_type              ask_ent;
   logic                   fak_cross;
   logic                   book_cross;
   logic [31:0]            fill;
   logic                   ins_go;

   // Slot storage and the shared scan unit.
   lobm_slot_mem #(.SLOTS(ORDER_SLOTS)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (scan_cnt_ff[SLOT_W-1:0]),
      .rd_data (rd_ent)
   );

   lobm_scan #(.SLOTS(ORDER_SLOTS)) u_scan (
      .clock     (clock),
      .reset     (reset),
      .clr       (scan_clr),
      .eval      (rd_pend_ff),
      .ent       (rd_ent),
      .ent_live  (valid_ff[rd_idx_ff]),
      .ent_idx   (rd_idx_ff),
      .key_id    (id_ff),
      .flags     (flags),
      .found_idx (found_idx),
      .free_idx  (free_idx),
      .bid_idx   (bid_idx),
      .ask_idx   (ask_idx),
      .bid_ent   (bid_ent),
      .ask_ent   (ask_ent)
   );

   assign out_free = !out_vld_ff || rsp_chan.ready;

   // Cross tests and the fill quantity of the next trade.
   always_comb begin
      fak_cross  = (side_ff == SIDE_BUY) ?
                   (flags.ask_found && (price_ff >= ask_ent.price)) :
                   (flags.bid_found && (price_ff <= bid_ent.price));
      book_cross = flags.bid_found && flags.ask_found &&
                   (bid_ent.price >= ask_ent.price) && (ntr_ff != MAX_TRADES);
      fill       = (bid_ent.remaining < ask_ent.remaining) ? bid_ent.remaining
                                                           : ask_ent.remaining;
   end

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      id_in          = id_ff;
      side_in        = side_ff;
      kind_in        = kind_ff;
      price_in       = price_ff;
      qty_in         = qty_ff;
      scan_match_in  = scan_match_ff;
      scan_cnt_in    = scan_cnt_ff;
      valid_in       = valid_ff;
      new_slot_in    = new_slot_ff;
      arrival_in     = arrival_ff;
      ntr_in         = ntr_ff;
      pend_vld_in    = pend_vld_ff;
      pend_bid_id_in = pend_bid_id_ff;
      pend_bid_pr_in = pend_bid_pr_ff;
      pend_ask_id_in = pend_ask_id_ff;
      pend_ask_pr_in = pend_ask_pr_ff;
      pend_fq_in     = pend_fq_ff;
      reply_in       = reply_ff;
      out_load       = 1'b0;
      out_status_in  = out_status_ff;
      out_bid_id_in  = out_bid_id_ff;
      out_bid_pr_in  = out_bid_pr_ff;
      out_ask_id_in  = out_ask_id_ff;
      out_ask_pr_in  = out_ask_pr_ff;
      out_fq_in      = out_fq_ff;
      out_last_in    = out_last_ff;
      issue          = 1'b0;
      scan_clr       = 1'b0;
      mem_we         = 1'b0;
      mem_wa         = '0;
      mem_wd         = '0;
      ins_go         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               mode_in     = req_chan.mode;
               id_in       = req_chan.order_id;
               side_in     = req_chan.side;
               kind_in     = req_chan.kind;
               price_in    = req_chan.price;
               qty_in      = req_chan.quantity;
               ntr_in      = '0;
               pend_vld_in = 1'b0;
               if (req_chan.mode inside {MODE_ADD, MODE_CANCEL, MODE_MODIFY}) begin
                  scan_match_in = 1'b0;
                  scan_cnt_in   = '0;
                  scan_clr      = 1'b1;
                  state_in      = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (scan_cnt_ff != CNT_W'(ORDER_SLOTS)) begin
               issue       = 1'b1;
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end else if (!rd_pend_ff) begin
               state_in = scan_match_ff ? S_MATCH : S_LOOKUP;
            end
         end

         S_LOOKUP: begin
            if (mode_ff == MODE_ADD) begin
               if (flags.found) begin
                  reply_in = ST_DUPLICATE;
                  state_in = S_REPLY;
               end else if ((kind_ff == KIND_FAK) && !fak_cross) begin
                  reply_in = ST_FAK_MISS;
                  state_in = S_REPLY;
               end else if (!flags.free_found) begin
                  reply_in = ST_FULL;
                  state_in = S_REPLY;
               end else begin
                  // Rest the order, then search for crosses.
                  ins_go           = 1'b1;
                  mem_we           = 1'b1;
                  mem_wa           = free_idx;
                  mem_wd.order_id  = id_ff;
                  mem_wd.side      = side_ff;
                  mem_wd.kind      = kind_ff;
                  mem_wd.price     = price_ff;
                  mem_wd.remaining = qty_ff;
                  mem_wd.arrival   = arrival_ff;
                  valid_in[free_idx] = 1'b1;
                  new_slot_in      = free_idx;
                  arrival_in       = arrival_ff + 32'd1;
                  scan_match_in    = 1'b1;
                  scan_cnt_in      = '0;
                  scan_clr         = 1'b1;
                  state_in         = S_SCAN;
               end
            end else if (!flags.found) begin
               reply_in = ST_UNKNOWN;
               state_in = S_REPLY;
            end else begin
               valid_in[found_idx] = 1'b0;
               if (mode_ff == MODE_CANCEL) begin
                  reply_in = ST_CANCELLED;
                  state_in = S_REPLY;
               end else begin
                  // Modify: add again with the resting order's kind.
                  kind_in     = flags.found_kind;
                  mode_in     = MODE_ADD;
                  scan_cnt_in = '0;
                  scan_clr    = 1'b1;
                  state_in    = S_SCAN;
               end
            end
         end

         S_MATCH: begin
            if (!book_cross) begin
               state_in = S_FINISH;
            end else if (!pend_vld_ff || out_free) begin
               // The earlier trade is not the last one: send it now.
               if (pend_vld_ff) begin
                  out_load      = 1'b1;
                  out_status_in = ST_TRADE;
                  out_bid_id_in = pend_bid_id_ff;
                  out_bid_pr_in = pend_bid_pr_ff;
                  out_ask_id_in = pend_ask_id_ff;
                  out_ask_pr_in = pend_ask_pr_ff;
                  out_fq_in     = pend_fq_ff;
                  out_last_in   = 1'b0;
               end
               pend_vld_in    = 1'b1;
               pend_bid_id_in = bid_ent.order_id;
               pend_bid_pr_in = bid_ent.price;
               pend_ask_id_in = ask_ent.order_id;
               pend_ask_pr_in = ask_ent.price;
               pend_fq_in     = fill;
               ntr_in         = ntr_ff + 1'b1;
               state_in       = S_WR_BID;
            end
         end

         S_WR_BID: begin
            mem_we           = 1'b1;
            mem_wa           = bid_idx;
            mem_wd           = bid_ent;
            mem_wd.remaining = bid_ent.remaining - pend_fq_ff;
            if (bid_ent.remaining == pend_fq_ff) begin
               valid_in[bid_idx] = 1'b0;
            end
            state_in = S_WR_ASK;
         end

         S_WR_ASK: begin
            mem_we           = 1'b1;
            mem_wa           = ask_idx;
            mem_wd           = ask_ent;
            mem_wd.remaining = ask_ent.remaining - pend_fq_ff;
            if (ask_ent.remaining == pend_fq_ff) begin
               valid_in[ask_idx] = 1'b0;
            end
            scan_cnt_in = '0;
            scan_clr    = 1'b1;
            state_in    = S_SCAN;
         end

         S_FINISH: begin
            if (out_free) begin
               // A fill-and-kill remainder never rests.
               if (kind_ff == KIND_FAK) begin
                  valid_in[new_slot_ff] = 1'b0;
               end
               out_load    = 1'b1;
               out_last_in = 1'b1;
               if (pend_vld_ff) begin
                  out_status_in = ST_TRADE;
                  out_bid_id_in = pend_bid_id_ff;
                  out_bid_pr_in = pend_bid_pr_ff;
                  out_ask_id_in = pend_ask_id_ff;
                  out_ask_pr_in = pend_ask_pr_ff;
                  out_fq_in     = pend_fq_ff;
               end else begin
                  out_status_in = ST_ACCEPTED;
                  out_bid_id_in = '0;
                  out_bid_pr_in = '0;
                  out_ask_id_in = '0;
                  out_ask_pr_in = '0;
                  out_fq_in     = '0;
               end
               pend_vld_in = 1'b0;
               state_in    = S_IDLE;
            end
         end

         S_REPLY: begin
            if (out_free) begin
               out_load      = 1'b1;
               out_status_in = reply_ff;
               out_bid_id_in = '0;
               out_bid_pr_in = '0;
               out_ask_id_in = '0;
               out_ask_pr_in = '0;
               out_fq_in     = '0;
               out_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Read pipeline alignment and output register occupancy.
   assign rd_pend_in = issue;
   assign rd_idx_in  = scan_cnt_ff[SLOT_W-1:0];
   assign out_vld_in = out_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_vld_ff);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         rd_pend_ff  <= 1'b0;
         valid_ff    <= '0;
         arrival_ff  <= '0;
         ntr_ff      <= '0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         scan_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         rd_pend_ff  <= rd_pend_in;
         valid_ff    <= valid_in;
         arrival_ff  <= arrival_in;
         ntr_ff      <= ntr_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
         scan_cnt_ff <= scan_cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      id_ff          <= id_in;
      side_ff        <= side_in;
      kind_ff        <= kind_in;
      price_ff       <= price_in;
      qty_ff         <= qty_in;
      scan_match_ff  <= scan_match_in;
      rd_idx_ff      <= rd_idx_in;
      new_slot_ff    <= new_slot_in;
      pend_bid_id_ff <= pend_bid_id_in;
      pend_bid_pr_ff <= pend_bid_pr_in;
      pend_ask_id_ff <= pend_ask_id_in;
      pend_ask_pr_ff <= pend_ask_pr_in;
      pend_fq_ff     <= pend_fq_in;
      reply_ff       <= reply_in;
      out_status_ff  <= out_status_in;
      out_bid_id_ff  <= out_bid_id_in;
      out_bid_pr_ff  <= out_bid_pr_in;
      out_ask_id_ff  <= out_ask_id_in;
      out_ask_pr_ff  <= out_ask_pr_in;
      out_fq_ff      <= out_fq_in;
      out_last_ff    <= out_last_in;
   end

   // Channel ports.
   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = out_vld_ff;
   assign rsp_chan.status        = out_status_ff;
   assign rsp_chan.bid_id        = out_bid_id_ff;
   assign rsp_chan.bid_price     = out_bid_pr_ff;
   assign rsp_chan.ask_id        = out_ask_id_ff;
   assign rsp_chan.ask_price     = out_ask_pr_ff;
   assign rsp_chan.fill_quantity = out_fq_ff;
   assign rsp_chan.last          = out_last_ff;

`ifndef NO_ASSERTIONS
   a_trade_limit : assert property (@(posedge clock) disable iff (reset)
      ntr_ff <= MAX_TRADES)
      else $error("trade count beyond limit");

   a_ask_after_bid : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WR_ASK |-> $past(state_ff) == S_WR_BID)
      else $error("ask update without bid update");

   a_insert_valid : assert property (@(posedge clock) disable iff (reset)
      ins_go |=> valid_ff[new_slot_ff])
      else $error("inserted order not marked valid");

   a_pending_counted : assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> ntr_ff != '0)
      else $error("pending trade without trade count");
`endif

endmodule
